// ===== hdl/upud_pkg.sv =====
`timescale 1ns / 1ps

package upud_pkg;

    // Escape parser phases
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_HI,
        PH_LO
    } t_phase;

    localparam logic [15:0] UNIT_PERCENT  = 16'h0025;
    localparam logic [15:0] HIGH_SURR     = 16'hD800;
    localparam logic [15:0] LOW_SURR      = 16'hDC00;
    localparam logic [20:0] SUPP_BASE     = 21'h010000;
    localparam logic [20:0] CP_LIMIT      = 21'h110000;
    localparam int          UPUD_QUEUE_DEPTH = 4;

    // Result group handed from the parser to the output side
    typedef struct packed {
        logic [1:0]       count;   // 1 to 3 results
        logic [2:0][15:0] unit;    // unit[0] goes out first
        logic             status;  // error result
        logic             done;    // last result closes the string
    } t_job;

endpackage

// ===== hdl/uri_percent_utf8_decoder.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | i_valid / o_ready  | i_code_unit, i_string_end
// output   | out       | o_valid / i_ready  | o_out_unit, o_status, o_run_last, o_string_done
// config   | in        | i_cfg_we           | i_cfg_wdata (keep_reserved)
//
// One code unit is taken per cycle while o_ready is high; the parser works each unit in the
// cycle of its transfer. An input unit that yields 1 to 3 results holds the output register
// for one result each, so with i_ready high the output sets the rate: one result per cycle.
// A job queue of QUEUE_DEPTH entries sits between parser and output stage; o_ready drops
// only while it is full. Synchronous active-low reset empties the queue and output register.
`timescale 1ns / 1ps

module uri_percent_utf8_decoder
    import upud_pkg::*;
#(
    parameter int QUEUE_DEPTH = UPUD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_unit,
    output logic        o_status,
    output logic        o_run_last,
    output logic        o_string_done
);

    logic r_keep;
    logic accept, push, pop, empty, full;
    t_job job_in, job_out;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_keep <= 1'b0;
        else if (i_cfg_we) r_keep <= i_cfg_wdata;
    end

    assign o_ready = !full;
    assign accept  = i_valid && !full;

    upud_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_keep       (r_keep),
        .i_accept     (accept),
        .i_code_unit  (i_code_unit),
        .i_string_end (i_string_end),
        .o_push       (push),
        .o_job        (job_in)
    );

    upud_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty),
        .o_full  (full)
    );

    upud_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_out),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_unit    (o_out_unit),
        .o_status      (o_status),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

endmodule

// ===== hdl/upud_front.sv =====
`timescale 1ns / 1ps

module upud_front
    import upud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_keep,
    input  logic        i_accept,
    input  logic [15:0] i_code_unit,
    input  logic        i_string_end,
    output logic        o_push,
    output t_job        o_job
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_need, n_need;
    logic [2:0]  r_seen, n_seen;
    logic [20:0] r_acc, n_acc;
    logic [3:0]  r_nib, n_nib;
    logic [15:0] r_hex_lo, n_hex_lo;
    logic [15:0] r_hex_hi, n_hex_hi;
    logic        r_drop, n_drop;

    // Hex digit decode: {valid, value}
    function automatic logic [4:0] hex_value(input logic [15:0] u);
        logic [4:0] v;
        v = 5'd0;
        if (u >= 16'h0030 && u <= 16'h0039) v = {1'b1, u[3:0]};
        else if ((u >= 16'h0041 && u <= 16'h0046) || (u >= 16'h0061 && u <= 16'h0066))
            v = {1'b1, u[3:0] + 4'd9};
        return v;
    endfunction

    function automatic logic [2:0] seq_length(input logic [7:0] b);
        logic [2:0] n;
        priority if (b < 8'h80) n = 3'd1;
        else if (b < 8'hC0)     n = 3'd0;
        else if (b < 8'hE0)     n = 3'd2;
        else if (b < 8'hF0)     n = 3'd3;
        else if (b < 8'hF8)     n = 3'd4;
        else                    n = 3'd0;
        return n;
    endfunction

    function automatic logic [7:0] lead_mask(input logic [2:0] need);
        logic [7:0] m;
        unique case (need)
            3'd1:    m = 8'h7F;
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'h0F;
            3'd4:    m = 8'h07;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // # $ & + , / : ; = ? @
    function automatic logic is_reserved(input logic [20:0] cp);
        logic r;
        unique case (cp)
            21'h23, 21'h24, 21'h26, 21'h2B, 21'h2C, 21'h2F,
            21'h3A, 21'h3B, 21'h3D, 21'h3F, 21'h40: r = 1'b1;
            default:                                 r = 1'b0;
        endcase
        return r;
    endfunction

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_need  <= 3'd0;
            r_seen  <= 3'd0;
            r_drop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_need  <= n_need;
            r_seen  <= n_seen;
            r_drop  <= n_drop;
        end
    end

    // Sequence payload
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_nib    <= n_nib;
        r_hex_lo <= n_hex_lo;
        r_hex_hi <= n_hex_hi;
    end

    // Parse one unit
    always_comb begin
        logic [4:0]  hv;
        logic [7:0]  b;
        logic [20:0] cp;
        logic [20:0] cpm;
        logic        err;
        logic        bad_cp;

        n_phase  = r_phase;
        n_need   = r_need;
        n_seen   = r_seen;
        n_acc    = r_acc;
        n_nib    = r_nib;
        n_hex_lo = r_hex_lo;
        n_hex_hi = r_hex_hi;
        n_drop   = r_drop;
        o_push   = 1'b0;
        o_job    = '0;
        err      = 1'b0;
        hv       = hex_value(i_code_unit);
        b        = {r_nib, hv[3:0]};
        cp       = 21'd0;
        cpm      = 21'd0;
        bad_cp   = 1'b0;

        if (i_accept && r_drop) begin
            if (i_string_end) n_drop = 1'b0;
        end else if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_code_unit == UNIT_PERCENT) begin
                        n_phase = PH_HI;
                        n_seen  = 3'd0;
                        n_need  = 3'd0;
                    end else begin
                        o_job.count   = 2'd1;
                        o_job.unit[0] = i_code_unit;
                    end
                end
                PH_PCT: begin
                    if (i_code_unit == UNIT_PERCENT) n_phase = PH_HI;
                    else err = 1'b1;
                end
                PH_HI: begin
                    if (!hv[4]) begin
                        err = 1'b1;
                    end else begin
                        n_nib = hv[3:0];
                        if (r_seen == 3'd0) n_hex_lo = i_code_unit;
                        n_phase = PH_LO;
                    end
                end
                PH_LO: begin
                    if (!hv[4]) begin
                        err = 1'b1;
                    end else if (r_seen == 3'd0) begin
                        n_hex_hi = i_code_unit;
                        n_need   = seq_length(b);
                        n_seen   = 3'd1;
                        n_acc    = {13'd0, b & lead_mask(n_need)};
                        if (n_need == 3'd0) err = 1'b1;
                    end else begin
                        if (b[7:6] != 2'b10) err = 1'b1;
                        n_acc  = {r_acc[14:0], b[5:0]};
                        n_seen = r_seen + 3'd1;
                    end
                    // Sequence complete: range checks, then build the results
                    if (!err && n_seen >= n_need) begin
                        cp  = n_acc;
                        cpm = cp - SUPP_BASE;
                        unique case (n_need)
                            3'd2:    bad_cp = cp < 21'h80;
                            3'd3:    bad_cp = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
                            3'd4:    bad_cp = cp < SUPP_BASE || cp >= CP_LIMIT;
                            default: bad_cp = 1'b0;
                        endcase
                        if (bad_cp) begin
                            err = 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                            if (cp >= SUPP_BASE) begin
                                o_job.count   = 2'd2;
                                o_job.unit[0] = HIGH_SURR | {6'd0, cpm[19:10]};
                                o_job.unit[1] = LOW_SURR | {6'd0, cpm[9:0]};
                            end else if (i_keep && cp != 21'd0 && is_reserved(cp)) begin
                                o_job.count   = 2'd3;
                                o_job.unit[0] = UNIT_PERCENT;
                                o_job.unit[1] = n_hex_lo;
                                o_job.unit[2] = n_hex_hi;
                            end else begin
                                o_job.count   = 2'd1;
                                o_job.unit[0] = cp[15:0];
                            end
                        end
                    end else if (!err) begin
                        n_phase = PH_PCT;
                    end
                end
                default: err = 1'b1;
            endcase

            // End of string inside an escape
            if (!err && i_string_end && n_phase != PH_IDLE) err = 1'b1;

            if (err) begin
                o_job        = '0;
                o_job.count  = 2'd1;
                o_job.status = 1'b1;
                n_drop       = !i_string_end;
            end
            if (err || i_string_end) begin
                n_phase = PH_IDLE;
                n_need  = 3'd0;
                n_seen  = 3'd0;
            end
            o_job.done = i_string_end || err;
            o_push     = o_job.count != 2'd0;
        end
    end

endmodule

// ===== hdl/upud_queue.sv =====
`timescale 1ns / 1ps

module upud_queue
    import upud_pkg::*;
#(
    parameter int DEPTH = UPUD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_empty = r_cnt == '0;
    assign o_full  = r_cnt == FULL;
    assign o_job   = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// ===== hdl/upud_back.sv =====
`timescale 1ns / 1ps

module upud_back
    import upud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_out_unit,
    output logic        o_status,
    output logic        o_run_last,
    output logic        o_string_done
);

    logic [1:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    logic [15:0] r_unit;
    logic        r_status, r_last, r_done;
    logic        load, last;
    logic [15:0] sel_unit;

    assign load = !r_valid || i_ready;
    assign last = r_idx == i_job.count - 2'd1;
    assign o_pop = load && !i_empty && last;

    // Pick the unit of the current group
    always_comb begin
        unique case (r_idx)
            2'd0:    sel_unit = i_job.unit[0];
            2'd1:    sel_unit = i_job.unit[1];
            default: sel_unit = i_job.unit[2];
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_unit   <= sel_unit;
            r_status <= i_job.status;
            r_last   <= last;
            r_done   <= last && i_job.done;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_unit    = r_unit;
    assign o_status      = r_status;
    assign o_run_last    = r_last;
    assign o_string_done = r_done;

endmodule

// ===== hdl/upud_checker.sv =====
`timescale 1ns / 1ps

module upud_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_out_unit,
    input logic        o_status,
    input logic        o_run_last,
    input logic        o_string_done
);

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A pending result is held until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // Error result is a lone, closing result with zero unit
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_run_last && o_string_done && o_out_unit == 16'd0)
        else $error("malformed error result");

    // String close only on the last result of a unit
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_done |-> o_run_last)
        else $error("string done without run last");

endmodule

bind uri_percent_utf8_decoder upud_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_unit    (o_out_unit),
    .o_status      (o_status),
    .o_run_last    (o_run_last),
    .o_string_done (o_string_done)
);

// ===== test/uri_percent_utf8_decoder_tb.sv =====
`timescale 1ns / 1ps

module uri_percent_utf8_decoder_tb;
    import upud_pkg::*;

    localparam int HALF_HIGH    = 6;
    localparam int HALF_LOW     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int NUM_PHASES   = 6;
    localparam int PHASE_UNITS  = 50;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 400000;

    // Escaped characters that keep_reserved leaves encoded
    localparam logic [87:0] RESERVED_SET = "#$&+,/:;=?@";

    typedef struct packed {
        logic [15:0] unit;
        logic        status;
        logic        run_last;
        logic        string_done;
    } t_dec_result;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
        logic        typed;
        t_dec_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_code_unit;
    logic        i_string_end;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_out_unit;
    logic        o_status;
    logic        o_run_last;
    logic        o_string_done;

    // Decoder shadow state
    bit          keep_res;
    t_phase      dec_phase;
    logic [2:0]  need_bytes;
    logic [2:0]  seen_bytes;
    logic [20:0] cp_acc;
    logic [3:0]  hi_nibble;
    logic [31:0] saved_hex;
    bit          dropping;

    t_dec_result step_out[$];
    t_dec_result expected_results[$];
    t_dec_result head_result;
    t_stim_row   dir_rows[$];

    int idle_pct = 25;
    int ready_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int units_sent = 0;
    int strings_sent = 0;
    int results_checked = 0;
    int errors_seen = 0;
    int mismatches = 0;

    uri_percent_utf8_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_unit   (i_code_unit),
        .i_string_end  (i_string_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_unit    (o_out_unit),
        .o_status      (o_status),
        .o_run_last    (o_run_last),
        .o_string_done (o_string_done)
    );

    always begin
        #HALF_LOW i_clk = 1'b1;
        #HALF_HIGH i_clk = 1'b0;
    end

    function automatic int hex_digit(input logic [15:0] u);
        if (u >= 16'h30 && u <= 16'h39) return int'(u - 16'h30);
        if (u >= 16'h41 && u <= 16'h46) return int'(u - 16'h41) + 10;
        if (u >= 16'h61 && u <= 16'h66) return int'(u - 16'h61) + 10;
        return -1;
    endfunction

    // Random letter case on A-F
    function automatic logic [15:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 16'h30 + {12'h000, n};
        return ($urandom_range(0, 1) ? 16'h41 : 16'h61) + {12'h000, n} - 16'd10;
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        if (b < 8'h80) return 3'd1;
        if (b < 8'hC0) return 3'd0;
        if (b < 8'hE0) return 3'd2;
        if (b < 8'hF0) return 3'd3;
        if (b < 8'hF8) return 3'd4;
        return 3'd0;
    endfunction

    function automatic logic [7:0] lead_bits(input logic [2:0] n);
        case (n)
            3'd1:    return 8'h7F;
            3'd2:    return 8'h1F;
            3'd3:    return 8'h0F;
            default: return 8'h07;
        endcase
    endfunction

    function automatic bit is_reserved(input logic [20:0] cp);
        for (int k = 0; k < 11; k++) begin
            if (cp == {13'h0, RESERVED_SET[k*8 +: 8]}) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] reserved_char();
        int k;
        k = $urandom_range(0, 10);
        return RESERVED_SET[k*8 +: 8];
    endfunction

    function automatic void clear_decoder();
        dec_phase  = PH_IDLE;
        need_bytes = '0;
        seen_bytes = '0;
        cp_acc     = '0;
        hi_nibble  = '0;
        saved_hex  = '0;
    endfunction

    // No gap unless idle_pct draws one; then mostly short ones, now and then a long one
    function automatic int pick_gap();
        if (idle_pct == 0 || hold_left > 0) return 0;
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want_v);
        mismatches++;
        $display("%0t: mismatch on %s at result %0d: got %h, want %h",
                 $time, what, results_checked, got, want_v);
    endtask

    // Decoded units for one input unit, left in step_out
    task automatic decode_step(input logic [15:0] u, input logic e);
        bit          err;
        bit          bad;
        int          h;
        logic [7:0]  b;
        logic [2:0]  n;
        logic [20:0] cp;
        logic [20:0] off;
        t_dec_result last_res;
        err = 1'b0;
        step_out.delete();
        if (dropping) begin
            if (e) dropping = 1'b0;
            return;
        end
        case (dec_phase)
            PH_IDLE: begin
                if (u == UNIT_PERCENT) begin
                    dec_phase  = PH_HI;
                    seen_bytes = '0;
                    need_bytes = '0;
                end else begin
                    step_out.push_back('{u, 1'b0, 1'b0, 1'b0});
                end
            end
            PH_PCT: begin
                if (u == UNIT_PERCENT) dec_phase = PH_HI;
                else err = 1'b1;
            end
            PH_HI: begin
                h = hex_digit(u);
                if (h < 0) begin
                    err = 1'b1;
                end else begin
                    hi_nibble = h[3:0];
                    if (seen_bytes == 0) saved_hex = {16'h0000, u};
                    dec_phase = PH_LO;
                end
            end
            default: begin
                h = hex_digit(u);
                if (h < 0) begin
                    err = 1'b1;
                end else begin
                    b = {hi_nibble, h[3:0]};
                    if (seen_bytes == 0) begin
                        // lead byte sets the sequence length
                        n = seq_len(b);
                        saved_hex[31:16] = u;
                        if (n == 0) begin
                            err = 1'b1;
                        end else begin
                            need_bytes = n;
                            seen_bytes = 3'd1;
                            cp_acc     = {13'h0, b & lead_bits(n)};
                        end
                    end else if (b[7:6] != 2'b10) begin
                        err = 1'b1;
                    end else begin
                        cp_acc     = {cp_acc[14:0], b[5:0]};
                        seen_bytes = seen_bytes + 3'd1;
                    end
                    if (!err && seen_bytes < need_bytes) begin
                        dec_phase = PH_PCT;
                    end else if (!err) begin
                        // overlong, surrogate and out-of-range checks
                        cp  = cp_acc;
                        bad = (need_bytes == 3'd2 && cp < 21'h80) ||
                              (need_bytes == 3'd3 &&
                               (cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF))) ||
                              (need_bytes == 3'd4 && (cp < SUPP_BASE || cp >= CP_LIMIT));
                        if (bad) begin
                            err = 1'b1;
                        end else begin
                            if (cp >= SUPP_BASE) begin
                                off = cp - SUPP_BASE;
                                step_out.push_back('{HIGH_SURR | {6'h00, off[19:10]},
                                                     1'b0, 1'b0, 1'b0});
                                step_out.push_back('{LOW_SURR | {6'h00, off[9:0]},
                                                     1'b0, 1'b0, 1'b0});
                            end else if (keep_res && cp != 0 && cp < 21'd128 &&
                                         is_reserved(cp)) begin
                                step_out.push_back('{UNIT_PERCENT, 1'b0, 1'b0, 1'b0});
                                step_out.push_back('{saved_hex[15:0], 1'b0, 1'b0, 1'b0});
                                step_out.push_back('{saved_hex[31:16], 1'b0, 1'b0, 1'b0});
                            end else begin
                                step_out.push_back('{cp[15:0], 1'b0, 1'b0, 1'b0});
                            end
                            dec_phase = PH_IDLE;
                        end
                    end
                end
            end
        endcase

        // string ending inside an escape is an error too
        if (!err && e && dec_phase != PH_IDLE) err = 1'b1;
        if (err) begin
            step_out.delete();
            step_out.push_back('{16'h0000, 1'b1, 1'b0, 1'b0});
            dropping = !e;
            clear_decoder();
        end else if (e) begin
            clear_decoder();
        end
        if (step_out.size() > 0) begin
            last_res = step_out.pop_back();
            last_res.run_last = 1'b1;
            if (e || err) last_res.string_done = 1'b1;
            step_out.push_back(last_res);
        end
    endtask

    // Offer one unit, wait for its transfer; called and returns at a falling edge
    task automatic send_unit(input logic [15:0] u, input logic e, input bit typed,
                             input t_dec_result want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_code_unit  <= u;
        i_string_end <= e;
        do @(posedge i_clk); while (!o_ready);
        decode_step(u, e);
        if (typed) begin
            step_out.delete();
            step_out.push_back(want);
        end
        foreach (step_out[k]) expected_results.push_back(step_out[k]);
        units_sent++;
        if (e) strings_sent++;
        @(negedge i_clk);
    endtask

    task automatic add_row(input logic [15:0] u, input logic e, input bit typed,
                           input logic [15:0] wu, input logic ws, input logic wr,
                           input logic wd);
        dir_rows.push_back('{u, e, typed, '{wu, ws, wr, wd}});
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_keep(input bit v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        keep_res = v;
    endtask

    // One string: mostly well-formed escapes and plain units, some damaged, some noise
    task automatic send_random_string();
        logic [15:0] str[$];
        logic [7:0]  seq[$];
        logic [15:0] u;
        logic [20:0] cp;
        logic [7:0]  cur;
        int          pieces;
        int          start;
        int          cls;
        int          nb;
        int          k;
        int          r;
        bit          cut;
        cut = 1'b0;
        if ($urandom_range(0, 99) < 8) begin
            pieces = $urandom_range(1, 8);
            repeat (pieces) begin
                case ($urandom_range(0, 2))
                    0:       str.push_back(UNIT_PERCENT);
                    1:       str.push_back(hex_char(4'($urandom_range(0, 15))));
                    default: str.push_back(16'($urandom_range(0, 16'hFFFF)));
                endcase
            end
        end else begin
            pieces = $urandom_range(1, 5);
            for (int p = 0; p < pieces && !cut; p++) begin
                if ($urandom_range(0, 99) < 35) begin
                    case ($urandom_range(0, 3))
                        0, 1:    u = 16'($urandom_range(32, 126));
                        2:       u = 16'($urandom_range(0, 16'hFFFF));
                        default: u = {8'h00, reserved_char()};
                    endcase
                    if (u == UNIT_PERCENT && $urandom_range(0, 3) != 0) u = 16'h7E;
                    str.push_back(u);
                end else begin
                    seq.delete();
                    cls = $urandom_range(0, 9);
                    case (cls)
                        0, 1, 2: begin
                            nb = 1;
                            cp = $urandom_range(0, 1) ? {13'h0, reserved_char()}
                                                      : 21'($urandom_range(0, 127));
                        end
                        3: begin
                            nb = 2;
                            cp = 21'($urandom_range(21'h80, 21'h7FF));
                        end
                        4, 5: begin
                            nb = 3;
                            cp = 21'($urandom_range(21'h800, 21'hFFFF));
                            if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h8000;
                        end
                        6: begin
                            nb = 4;
                            cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                        end
                        7: begin
                            // overlong forms
                            nb = $urandom_range(2, 4);
                            cp = 21'($urandom_range(0, nb == 2 ? 21'h7F :
                                                       (nb == 3 ? 21'h7FF : 21'hFFFF)));
                        end
                        8: begin
                            // surrogate or above the Unicode range
                            if ($urandom_range(0, 1)) begin
                                nb = 3;
                                cp = 21'($urandom_range(21'hD800, 21'hDFFF));
                            end else begin
                                nb = 4;
                                cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                            end
                        end
                        default: begin
                            if ($urandom_range(0, 1)) begin
                                nb = 0;
                                seq.push_back($urandom_range(0, 1)
                                              ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF)));
                            end else begin
                                nb = $urandom_range(2, 4);
                                cp = 21'($urandom_range(nb == 2 ? 21'h80 :
                                                        (nb == 3 ? 21'h800 : 21'h10000),
                                                        nb == 2 ? 21'h7FF :
                                                        (nb == 3 ? 21'hFFFF : 21'h10FFFF)));
                            end
                        end
                    endcase
                    // UTF-8 encoding
                    case (nb)
                        1: seq.push_back(cp[7:0]);
                        2: begin
                            seq.push_back({3'b110, cp[10:6]});
                            seq.push_back({2'b10, cp[5:0]});
                        end
                        3: begin
                            seq.push_back({4'b1110, cp[15:12]});
                            seq.push_back({2'b10, cp[11:6]});
                            seq.push_back({2'b10, cp[5:0]});
                        end
                        4: begin
                            seq.push_back({5'b11110, cp[20:18]});
                            seq.push_back({2'b10, cp[17:12]});
                            seq.push_back({2'b10, cp[11:6]});
                            seq.push_back({2'b10, cp[5:0]});
                        end
                        default: ;
                    endcase
                    // broken continuation byte
                    if (cls == 9 && nb > 1) begin
                        k = $urandom_range(1, nb - 1);
                        cur = seq[k];
                        cur[7:6] = $urandom_range(0, 1) ? 2'b00 : 2'b11;
                        seq[k] = cur;
                    end
                    start = str.size();
                    foreach (seq[j]) begin
                        cur = seq[j];
                        str.push_back(UNIT_PERCENT);
                        str.push_back(hex_char(cur[7:4]));
                        str.push_back(hex_char(cur[3:0]));
                    end
                    // damage: bad hex digit or missing percent, or cut the string short
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        k = start + $urandom_range(0, str.size() - start - 1);
                        u = 16'($urandom_range(0, 16'hFFFF));
                        if (hex_digit(u) >= 0 || u == UNIT_PERCENT) u = 16'h47;
                        str[k] = u;
                    end else if (r < 9) begin
                        k = $urandom_range(1, str.size() - start - 1);
                        while (str.size() > start + k) void'(str.pop_back());
                        cut = 1'b1;
                    end
                end
            end
        end
        foreach (str[j]) send_unit(str[j], j == str.size() - 1, 1'b0, '0);
    endtask

    // Output side: random back-pressure plus one long hold while input is offered
    always @(negedge i_clk) begin
        if (!hold_done && units_sent >= HOLD_AT && i_valid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else if (ready_gap > 0) begin
            i_ready <= 1'b0;
            ready_gap--;
        end else begin
            i_ready <= 1'b1;
            ready_gap = pick_gap();
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_out_unit, 16'h0000);
            end else begin
                head_result = expected_results.pop_front();
                if (o_out_unit !== head_result.unit)
                    report_mismatch("out_unit", o_out_unit, head_result.unit);
                if (o_status !== head_result.status)
                    report_mismatch("status", {15'd0, o_status},
                                    {15'd0, head_result.status});
                if (o_run_last !== head_result.run_last)
                    report_mismatch("run_last", {15'd0, o_run_last},
                                    {15'd0, head_result.run_last});
                if (o_string_done !== head_result.string_done)
                    report_mismatch("string_done", {15'd0, o_string_done},
                                    {15'd0, head_result.string_done});
                if (head_result.status) errors_seen++;
            end
            results_checked++;
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Watchdog expired with %0d results outstanding", expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int phase_start;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = 1'b0;
        i_valid      = 1'b0;
        i_code_unit  = '0;
        i_string_end = 1'b0;
        keep_res     = 1'b0;
        dropping     = 1'b0;
        clear_decoder();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset configuration (decode all)
        // plain units and extremes
        add_row(16'h0041, 1'b0, 1'b1, 16'h0041, 1'b0, 1'b1, 1'b0);
        add_row(16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b0);
        add_row(16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b1);
        // %2f with lowercase hex closes the string
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("2", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("f", 1'b1, 1'b1, "/", 1'b0, 1'b1, 1'b1);
        // two-byte sequence %C3%a9
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("C", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("3", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("a", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("9", 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        // bad hex digit, rest of string dropped up to the end mark
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("G", 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
        add_row("x", 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        // invalid lead byte F8
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("F", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("8", 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
        add_row("Z", 1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        // missing percent before continuation
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("E", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("2", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("A", 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
        // string ends inside an escape
        add_row("%", 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
        add_row("4", 1'b1, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1);
        foreach (dir_rows[k])
            send_unit(dir_rows[k].unit, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].want);

        // Random phases, alternating keep_reserved, some with no idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_keep(ph % 2 == 0);
            idle_pct = (ph % 3 == 1) ? 0 : 20 + 10 * ph;
            phase_start = units_sent;
            while (units_sent - phase_start < PHASE_UNITS) send_random_string();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d code units in %0d strings over %0d keep_reserved phases",
                 units_sent, strings_sent, NUM_PHASES);
        $display("with a long output hold; %0d results checked, %0d were error results",
                 results_checked, errors_seen);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
